FILE: rtl/sle_pkg.sv
// Shared types, codes and sizes for the sorted list engine.
`default_nettype none
package sle_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SORT   = 3'd4,
    CMD_READ   = 3'd5,
    CMD_RSVD6  = 3'd6,
    CMD_RSVD7  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_RANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_INSERT,
    OP_SORT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_e;

  typedef struct packed {
    cell_op_e          op;
    logic [VAL_W-1:0]  value;
    logic              phase;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/sle_cell.sv
// One list entry: shifts on push and insert, compares and swaps with its right neighbor on sort.
`default_nettype none
module sle_cell (
  input  wire logic                     clk_i,
  input  wire sle_pkg::cell_ctl_t       ctl_i,
  input  wire logic                     valid_i,
  input  wire logic                     odd_i,
  input  wire logic [sle_pkg::VAL_W-1:0] left_i,
  input  wire logic [sle_pkg::VAL_W-1:0] right_i,
  input  wire logic                     right_valid_i,
  input  wire logic                     pass_i,
  input  wire logic                     swap_i,
  output logic                          pass_o,
  output logic                          swap_o,
  output logic                          match_o,
  output logic [sle_pkg::VAL_W-1:0]     entry_o
);
  import sle_pkg::*;

  logic [VAL_W-1:0] entry_q, entry_d;
  logic             lt;
  logic             pair_left;

  assign lt        = valid_i && ($signed(entry_q) < $signed(ctl_i.value));
  assign pass_o    = pass_i && lt && (ctl_i.op == OP_INSERT);
  assign pair_left = (odd_i == ctl_i.phase);
  assign swap_o    = (ctl_i.op == OP_SORT) && pair_left && valid_i && right_valid_i &&
                     ($signed(right_i) < $signed(entry_q));
  assign match_o   = valid_i && (entry_q == ctl_i.value);
  assign entry_o   = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      OP_PUSH, OP_INSERT: begin
        if (!pass_i) begin
          entry_d = left_i;
        end else if (!pass_o) begin
          entry_d = ctl_i.value;
        end
      end
      OP_SORT: begin
        if (swap_o) begin
          entry_d = right_i;
        end else if (!pair_left && swap_i) begin
          entry_d = left_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

FILE: rtl/sorted_list_engine.sv
// Top level of the sorted list engine: command sequencer, cell row and result register.
// Usage:
//   Commands arrive on the s_axis channel: tuser carries the command code, tdata
//   carries the value (bits 31:0) and the read position (bits 35:32). Each command
//   yields one result transfer on m_axis: tuser carries the status, tdata carries
//   found position (3:0), read value (35:4) and entry count (40:36).
//   Push, insert, find, clear, read and undefined codes complete in the accept cycle;
//   the result is registered and valid in the cycle after. A sort runs an odd-even
//   exchange over the row of cells, during which no command is accepted; its result
//   is registered as the last exchange pass ends. Sustained rate is one command per
//   cycle while the receiver takes each result, except during sorts.
//   The result register frees itself in the cycle the receiver takes it, so a new
//   command is accepted while a result is being transferred. While the receiver
//   stalls with a result pending, s_axis_tready_o stays low and nothing is lost.
//   Reset empties the list (count 0) and drops any pending result; entry contents
//   are not cleared and are never observed before being written.
`default_nettype none
module sorted_list_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // value[31:0], position[35:32], zero pad
  input  wire logic [2:0]  s_axis_tuser_i,   // cmd[2:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // found_position[3:0], read_value[35:4],
                                             // entry_count[40:36], zero pad
  output logic [1:0]       m_axis_tuser_o    // status[1:0]
);
  import sle_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] sort_cnt_q, sort_cnt_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [3:0]       out_fpos_q, out_fpos_d;
  logic [VAL_W-1:0] out_rval_q, out_rval_d;

  cell_ctl_t        ctl;
  cmd_e             cmd;
  logic [VAL_W-1:0] in_value;
  logic [3:0]       in_pos;
  logic             accept, full, in_range, any_match, sort_done;
  logic [IDX_W-1:0] match_idx, read_idx;

  logic [VAL_W-1:0] entry_w [DEPTH];
  logic [DEPTH:0]   pass_w;
  logic [DEPTH:0]   swap_w;
  logic [DEPTH-1:0] match_w;
  logic [DEPTH-1:0] valid_w;

  assign cmd      = cmd_e'(s_axis_tuser_i);
  assign in_value = s_axis_tdata_i[31:0];
  assign in_pos   = s_axis_tdata_i[35:32];

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CNT_W'(DEPTH));
  assign in_range        = (32'(in_pos) < 32'(count_q));
  assign read_idx        = IDX_W'(in_pos);
  assign sort_done       = (state_q == ST_SORT) && (sort_cnt_q == IDX_W'(DEPTH - 1));

  always_comb begin
    ctl.value = in_value;
    ctl.phase = sort_cnt_q[0];
    ctl.op    = OP_HOLD;
    if (state_q == ST_SORT) begin
      ctl.op = OP_SORT;
    end else if (accept && !full) begin
      if (cmd == CMD_PUSH) begin
        ctl.op = OP_PUSH;
      end else if (cmd == CMD_INSERT) begin
        ctl.op = OP_INSERT;
      end
    end
  end

  assign pass_w[0] = 1'b1;
  assign swap_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_v, right_v;
    logic             right_vld;
    assign valid_w[i] = (CNT_W'(i) < count_q);
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v   = '0;
      assign right_vld = 1'b0;
    end else begin : g_inner
      assign right_v   = entry_w[i+1];
      assign right_vld = (CNT_W'(i + 1) < count_q);
    end
    sle_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .valid_i       (valid_w[i]),
      .odd_i         (1'(i % 2)),
      .left_i        (left_v),
      .right_i       (right_v),
      .right_valid_i (right_vld),
      .pass_i        (pass_w[i]),
      .swap_i        (swap_w[i]),
      .pass_o        (pass_w[i+1]),
      .swap_o        (swap_w[i+1]),
      .match_o       (match_w[i]),
      .entry_o       (entry_w[i])
    );
  end

  always_comb begin
    match_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_w[i]) begin
        match_idx = IDX_W'(i);
      end
    end
  end
  assign any_match = |match_w;

  always_comb begin
    state_d      = state_q;
    sort_cnt_d   = sort_cnt_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_fpos_d   = out_fpos_q;
    out_rval_d   = out_rval_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_status_d = STAT_OK;
          out_fpos_d   = '0;
          out_rval_d   = '0;
          out_valid_d  = 1'b1;
          unique case (cmd)
            CMD_PUSH, CMD_INSERT: begin
              if (full) begin
                out_status_d = STAT_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_FIND: begin
              if (any_match) begin
                out_fpos_d = 4'(match_idx);
              end else begin
                out_status_d = STAT_NOTFOUND;
              end
            end
            CMD_CLEAR: count_d = '0;
            CMD_SORT: begin
              out_valid_d = 1'b0;
              sort_cnt_d  = '0;
              state_d     = ST_SORT;
            end
            CMD_READ: begin
              if (in_range) begin
                out_rval_d = entry_w[read_idx];
              end else begin
                out_status_d = STAT_RANGE;
              end
            end
            default: out_status_d = STAT_OK;
          endcase
        end
      end
      ST_SORT: begin
        sort_cnt_d = sort_cnt_q + IDX_W'(1);
        if (sort_done) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_fpos_d   = '0;
          out_rval_d   = '0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sort_cnt_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sort_cnt_q  <= sort_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_fpos_q   <= out_fpos_d;
    out_rval_q   <= out_rval_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {7'd0, 5'(count_q), out_rval_q, out_fpos_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count exceeds depth");

  a_sort_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |-> !s_axis_tready_o)
    else $error("command accepted during sort");

  a_sort_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sort_done |-> !out_valid_q)
    else $error("sort result would overwrite a pending result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STAT_FULL)) |-> full)
    else $error("full status reported with room left");
`endif

endmodule
`default_nettype wire
